// ===== sv/ddpe_pkg.sv =====
// Shared types, constants and helper functions for the pose update pipeline.
`default_nettype none
package ddpe_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 18;
  localparam int NUM_ITER      = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;

  localparam int DATA_W    = 32;
  localparam int STEP_W    = 24;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROT_OFFSET = CFG_IDX_W'(1);

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  function automatic logic [63:0] pi_at(input int k);
    return (PI_Q60 + (64'd1 << (59 - k))) >> (60 - k);
  endfunction

  localparam logic [63:0] PI_FULL    = pi_at(FRAC_BITS + 1);
  localparam logic [63:0] PI_HALF    = pi_at(FRAC_BITS);
  localparam logic [63:0] PI_QUARTER = pi_at(FRAC_BITS - 1);

  function automatic int red_steps();
    int n;
    n = 40;
    for (int i = 40; i >= 1; i--) begin
      if ((PI_FULL << (i - 1)) >= 64'h80000000) n = i;
    end
    return n;
  endfunction

  localparam int RED_STEPS = red_steps();
  localparam int A_W       = 34;
  localparam int R_W       = FRAC_BITS + 5;
  localparam int ANG_W     = 34;
  localparam int CS_W      = FRAC_BITS + 2;
  localparam int WI_W      = 64 - FRAC_BITS;
  localparam int V_W       = 64 - FRAC_BITS;

  localparam int RED_LAT  = RED_STEPS + 2;
  localparam int COR_LAT  = NUM_ITER + 1;
  localparam int SIDE_LAT = RED_LAT + COR_LAT;

  localparam logic signed [ANG_W-1:0] GAIN_Q30 = ANG_W'(652032874);

  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] a;
    case (i)
      0:       a = 32'd843314857;
      1:       a = 32'd497837829;
      2:       a = 32'd263043837;
      3:       a = 32'd133525159;
      4:       a = 32'd67021687;
      5:       a = 32'd33543516;
      6:       a = 32'd16775851;
      7:       a = 32'd8388437;
      8:       a = 32'd4194283;
      9:       a = 32'd2097149;
      default: a = (i <= 29) ? (32'd1 << (30 - i)) : 32'd0;
    endcase
    return a;
  endfunction

  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] ph;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] w;
  } side_t;

endpackage
`default_nettype wire

// ===== sv/ddpe_reduce.sv =====
// Heading reduction into [-pi/2, pi/2] with a fold flag, one compare-subtract per stage.
`default_nettype none
module ddpe_reduce (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [ddpe_pkg::DATA_W-1:0]  heading,
  output logic signed [ddpe_pkg::ANG_W-1:0]        z,
  output logic                                     flip
);

  localparam int AW = ddpe_pkg::A_W;
  localparam int RW = ddpe_pkg::R_W;
  localparam int NS = ddpe_pkg::RED_STEPS;
  localparam logic [AW-1:0] BIAS = AW'(ddpe_pkg::PI_FULL << (NS - 1));
  localparam logic signed [RW-1:0] FULL_R = $signed(ddpe_pkg::PI_FULL[RW-1:0]);
  localparam logic signed [RW-1:0] HALF_R = $signed(ddpe_pkg::PI_HALF[RW-1:0]);
  localparam logic signed [RW-1:0] QUAR_R = $signed(ddpe_pkg::PI_QUARTER[RW-1:0]);

  logic [AW-1:0] acc [NS+1];
  logic signed [RW-1:0] r0, r1, r2;
  logic fl;

  always_ff @(posedge clk) begin
    if (en) begin
      acc[0] <= {{(AW - ddpe_pkg::DATA_W){heading[ddpe_pkg::DATA_W-1]}}, heading} + BIAS;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam logic [AW-1:0] SUB = AW'(ddpe_pkg::PI_FULL << (NS - 1 - j));
    always_ff @(posedge clk) begin
      if (en) begin
        acc[j+1] <= (acc[j] >= SUB) ? acc[j] - SUB : acc[j];
      end
    end
  end

  always_comb begin
    r0 = $signed(acc[NS][RW-1:0]);
    r1 = (r0 > HALF_R) ? r0 - FULL_R : r0;
    fl = 1'b0;
    r2 = r1;
    if (r1 > QUAR_R) begin
      r2 = r1 - HALF_R;
      fl = 1'b1;
    end else if (r1 < -QUAR_R) begin
      r2 = r1 + HALF_R;
      fl = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z    <= $signed({{(ddpe_pkg::ANG_W - RW){r2[RW-1]}}, r2}) <<< (30 - ddpe_pkg::FRAC_BITS);
      flip <= fl;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ddpe_cordic.sv =====
// Pipelined rotation-mode CORDIC giving rounded, clamped cosine and sine.
`default_nettype none
module ddpe_cordic (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [ddpe_pkg::ANG_W-1:0]   z_in,
  input  wire logic                                flip_in,
  output logic signed [ddpe_pkg::CS_W-1:0]         cos_out,
  output logic signed [ddpe_pkg::CS_W-1:0]         sin_out
);

  localparam int AW = ddpe_pkg::ANG_W;
  localparam int NI = ddpe_pkg::NUM_ITER;
  localparam int RS = 30 - ddpe_pkg::FRAC_BITS;
  localparam logic signed [AW-1:0] RND  = AW'(64'sd1 <<< (RS - 1));
  localparam logic signed [AW-1:0] UNIT = AW'(64'sd1 <<< ddpe_pkg::FRAC_BITS);

  logic signed [AW-1:0] xs [NI];
  logic signed [AW-1:0] ys [NI];
  logic signed [AW-1:0] zs [NI];
  logic fs [NI];

  for (genvar i = 0; i < NI; i++) begin : g_iter
    localparam logic signed [AW-1:0] AT = $signed(AW'(ddpe_pkg::atan_q30(i)));
    logic signed [AW-1:0] xp, yp, zp;
    logic fp;
    if (i == 0) begin : g_first
      assign xp = ddpe_pkg::GAIN_Q30;
      assign yp = '0;
      assign zp = z_in;
      assign fp = flip_in;
    end else begin : g_next
      assign xp = xs[i-1];
      assign yp = ys[i-1];
      assign zp = zs[i-1];
      assign fp = fs[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (zp >= 0) begin
          xs[i] <= xp - (yp >>> i);
          ys[i] <= yp + (xp >>> i);
          zs[i] <= zp - AT;
        end else begin
          xs[i] <= xp + (yp >>> i);
          ys[i] <= yp - (xp >>> i);
          zs[i] <= zp + AT;
        end
        fs[i] <= fp;
      end
    end
  end

  function automatic logic signed [ddpe_pkg::CS_W-1:0] to_unit(
    input logic signed [AW-1:0] v,
    input logic neg
  );
    logic signed [AW-1:0] t;
    t = (v + RND) >>> RS;
    if (t > UNIT) t = UNIT;
    if (t < -UNIT) t = -UNIT;
    if (neg) t = -t;
    return t[ddpe_pkg::CS_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= to_unit(xs[NI-1], fs[NI-1]);
      sin_out <= to_unit(ys[NI-1], fs[NI-1]);
    end
  end

endmodule
`default_nettype wire

// ===== sv/ddpe_update.sv =====
// Velocity, Euler step and saturation stages, ending in the output register.
`default_nettype none
module ddpe_update (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire logic signed [ddpe_pkg::CS_W-1:0]    c,
  input  wire logic signed [ddpe_pkg::CS_W-1:0]    s,
  input  wire ddpe_pkg::side_t                     side,
  input  wire logic [ddpe_pkg::STEP_W-1:0]         step_time,
  input  wire logic signed [ddpe_pkg::DATA_W-1:0]  rot_offset,
  output logic                                     out_valid,
  output logic signed [ddpe_pkg::DATA_W-1:0]       next_x,
  output logic signed [ddpe_pkg::DATA_W-1:0]       next_y,
  output logic signed [ddpe_pkg::DATA_W-1:0]       next_heading,
  output logic                                     overflow
);

  localparam int F    = ddpe_pkg::FRAC_BITS;
  localparam int DW   = ddpe_pkg::DATA_W;
  localparam int CW   = ddpe_pkg::CS_W;
  localparam int WW   = ddpe_pkg::WI_W;
  localparam int VW   = ddpe_pkg::V_W;
  localparam int SW   = ddpe_pkg::STEP_W;
  localparam int HP_W = DW + SW + 1;
  localparam int PC_W = DW + CW;
  localparam int QS_W = WW + CW;
  localparam int SM_W = QS_W + 1;
  localparam int P_W  = VW + SW + 1;

  localparam logic signed [P_W-1:0] MAX32 = P_W'(64'sh7FFFFFFF);
  localparam logic signed [P_W-1:0] MIN32 = -MAX32 - P_W'(1);
  localparam logic signed [P_W-1:0] LIM62 = P_W'(64'sh4000000000000000);
  localparam logic signed [P_W-1:0] RNDP  = P_W'(64'sd1 <<< (F - 1));
  localparam logic signed [63:0]    RND64 = 64'sd1 <<< (F - 1);

  logic [4:0] vld;

  logic signed [WW-1:0]   wi1;
  logic signed [HP_W-1:0] hp1;
  logic signed [CW-1:0]   c1, s1;
  logic signed [DW-1:0]   v1, px1, py1, ph1;

  logic signed [PC_W-1:0] pc2, ps2;
  logic signed [QS_W-1:0] qs2, qc2;
  logic signed [DW-1:0]   px2, py2, nh2;
  logic                   ovh2;

  logic signed [VW-1:0]   vx3, vy3;
  logic signed [DW-1:0]   px3, py3, nh3;
  logic                   ovh3;

  logic signed [P_W-1:0]  prx4, pry4;
  logic signed [DW-1:0]   px4, py4, nh4;
  logic                   ovh4;

  logic signed [63:0]     wprod;
  logic signed [63:0]     wround;
  logic signed [P_W-1:0]  hsum;
  logic signed [SM_W-1:0] sx, sy, sxr, syr;
  logic signed [P_W-1:0]  step_s;
  logic signed [P_W-1:0]  sumx, sumy;

  function automatic logic signed [P_W-1:0] clamp_rnd(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] t;
    t = p;
    if (t > LIM62) t = LIM62;
    if (t < -LIM62) t = -LIM62;
    return (t + RNDP) >>> F;
  endfunction

  function automatic logic is_ovf(input logic signed [P_W-1:0] v);
    return (v > MAX32) || (v < MIN32);
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] t;
    t = v;
    if (v > MAX32) t = MAX32;
    if (v < MIN32) t = MIN32;
    return t[DW-1:0];
  endfunction

  always_comb begin
    wprod  = side.w * rot_offset;
    wround = (wprod + RND64) >>> F;
    step_s = $signed({{(P_W - SW){1'b0}}, step_time});
    hsum   = P_W'(ph1) + ((P_W'(hp1) + RNDP) >>> F);
    sx     = SM_W'(pc2) + SM_W'(qs2);
    sy     = SM_W'(ps2) - SM_W'(qc2);
    sxr    = (sx + SM_W'(RNDP)) >>> F;
    syr    = (sy + SM_W'(RNDP)) >>> F;
    sumx   = P_W'(px4) + clamp_rnd(prx4);
    sumy   = P_W'(py4) + clamp_rnd(pry4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wi1 <= wround[WW-1:0];
      hp1 <= HP_W'(side.w) * HP_W'(step_s);
      c1  <= c;
      s1  <= s;
      v1  <= side.v;
      px1 <= side.px;
      py1 <= side.py;
      ph1 <= side.ph;

      pc2  <= PC_W'(v1) * PC_W'(c1);
      ps2  <= PC_W'(v1) * PC_W'(s1);
      qs2  <= QS_W'(wi1) * QS_W'(s1);
      qc2  <= QS_W'(wi1) * QS_W'(c1);
      px2  <= px1;
      py2  <= py1;
      nh2  <= sat32(hsum);
      ovh2 <= is_ovf(hsum);

      vx3  <= sxr[VW-1:0];
      vy3  <= syr[VW-1:0];
      px3  <= px2;
      py3  <= py2;
      nh3  <= nh2;
      ovh3 <= ovh2;

      prx4 <= P_W'(vx3) * step_s;
      pry4 <= P_W'(vy3) * step_s;
      px4  <= px3;
      py4  <= py3;
      nh4  <= nh3;
      ovh4 <= ovh3;

      next_x       <= sat32(sumx);
      next_y       <= sat32(sumy);
      next_heading <= nh4;
      overflow     <= ovh4 | is_ovf(sumx) | is_ovf(sumy);
    end
  end

  assign out_valid = vld[4];

endmodule
`default_nettype wire

// ===== sv/diff_drive_pose_euler_step.sv =====
// Top level of the differential-drive pose update pipeline.
`default_nettype none
// Takes one pose and command beat per cycle while the output is not stalled
// and returns the pose after one forward-Euler step of length step_time,
// with sine and cosine of the heading from a pipelined CORDIC. The stages
// are heading reduction (one modulo step per stage), CORDIC (one rotation
// per stage plus rounding) and multiply, integrate and saturate. The whole
// pipeline advances together whenever the output register is empty or taken,
// so a stalled output holds every stage. Configuration writes are always
// accepted and take effect on beats still in the pipeline, so issue them
// only while the pipeline is empty.
module diff_drive_pose_euler_step (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [159:0]                       s_tdata,   // pose_x, pose_y, pose_heading, linear_speed, turn_rate
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [95:0]                             m_tdata,   // next_x, next_y, next_heading
  output logic [0:0]                              m_tuser,   // overflow
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ddpe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                        cfg_data
);

  localparam int SL = ddpe_pkg::SIDE_LAT;

  logic [ddpe_pkg::STEP_W-1:0]        step_time;
  logic signed [ddpe_pkg::DATA_W-1:0] rot_offset;

  logic adv;
  ddpe_pkg::side_t side_in;
  ddpe_pkg::side_t sd [SL];
  logic [SL-1:0] vd;

  logic signed [ddpe_pkg::ANG_W-1:0] z_red;
  logic                              flip_red;
  logic signed [ddpe_pkg::CS_W-1:0]  cos_v, sin_v;
  logic signed [ddpe_pkg::DATA_W-1:0] nx, ny, nh;
  logic ovf;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time  <= ddpe_pkg::STEP_W'(6554);
      rot_offset <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ddpe_pkg::REG_STEP_TIME:  step_time  <= cfg_data[ddpe_pkg::STEP_W-1:0];
        ddpe_pkg::REG_ROT_OFFSET: rot_offset <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    side_in.px = $signed(s_tdata[31:0]);
    side_in.py = $signed(s_tdata[63:32]);
    side_in.ph = $signed(s_tdata[95:64]);
    side_in.v  = $signed(s_tdata[127:96]);
    side_in.w  = $signed(s_tdata[159:128]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (adv) begin
      vd <= {vd[SL-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= side_in;
      for (int k = 1; k < SL; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  ddpe_reduce u_reduce (
    .clk     (clk),
    .en      (adv),
    .heading (side_in.ph),
    .z       (z_red),
    .flip    (flip_red)
  );

  ddpe_cordic u_cordic (
    .clk     (clk),
    .en      (adv),
    .z_in    (z_red),
    .flip_in (flip_red),
    .cos_out (cos_v),
    .sin_out (sin_v)
  );

  ddpe_update u_update (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_valid     (vd[SL-1]),
    .c            (cos_v),
    .s            (sin_v),
    .side         (sd[SL-1]),
    .step_time    (step_time),
    .rot_offset   (rot_offset),
    .out_valid    (m_tvalid),
    .next_x       (nx),
    .next_y       (ny),
    .next_heading (nh),
    .overflow     (ovf)
  );

  assign m_tdata = {nh, ny, nx};
  assign m_tuser = ovf;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the pose update pipeline: predictor, directed table, random beats.
`default_nettype none
module tb_top;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] v;
    logic signed [31:0] ph;
    logic signed [31:0] py;
    logic signed [31:0] px;
  } pose_cmd_t;

  typedef struct {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nh;
    logic        ov;
  } pose_res_t;

  typedef struct {
    pose_cmd_t cmd;
    logic      known;
    pose_res_t res;
  } row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [159:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [ddpe_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]  cfg_data;

  diff_drive_pose_euler_step dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  longint    step_len;
  longint    icr_offset;
  pose_res_t pending_poses[$];
  int        mismatches;
  int        stall_mode;     // 0 random bursts, 1 none, 2 long hold
  int        hold_cycles;
  int        idle_left;

  localparam int ATAN_TBL [30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("diff_drive_pose_euler_step test failed");
    $finish;
  end

  function automatic longint round_sh(longint v, int k);
    return (v + (64'sd1 << (k - 1))) >>> k;
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic longint sat_field(longint v, ref logic ov);
    if (v > 64'sd2147483647) begin
      ov = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ov = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint scale_by_step(longint v);
    longint unsigned m, p, lim;
    lim = 64'h4000000000000000;
    m = (v < 0) ? -v : v;
    if (step_len != 0 && m > lim / longint'(step_len)) p = lim;
    else p = m * step_len;
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic pose_res_t predict_pose(pose_cmd_t c);
    pose_res_t r;
    longint full, half, quarter, ang, x, y, z, t, co, si, wv, wi, vx, vy;
    logic flip, ov;
    full = ddpe_pkg::pi_at(ddpe_pkg::FRAC_BITS + 1);
    half = ddpe_pkg::pi_at(ddpe_pkg::FRAC_BITS);
    quarter = ddpe_pkg::pi_at(ddpe_pkg::FRAC_BITS - 1);
    flip = 0;
    ov = 0;
    ang = longint'(c.ph) % full;
    if (ang < 0) ang += full;
    if (ang > half) ang -= full;
    if (ang > quarter) begin
      ang -= half;
      flip = 1;
    end else if (ang < -quarter) begin
      ang += half;
      flip = 1;
    end
    z = ang <<< (30 - ddpe_pkg::FRAC_BITS);
    x = 652032874;
    y = 0;
    for (int i = 0; i < ddpe_pkg::CORDIC_STAGES && i < 30; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_TBL[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_TBL[i];
      end
      x = t;
    end
    co = unit_clamp(round_sh(x, 30 - ddpe_pkg::FRAC_BITS));
    si = unit_clamp(round_sh(y, 30 - ddpe_pkg::FRAC_BITS));
    if (flip) begin
      co = -co;
      si = -si;
    end
    wv = longint'(c.w);
    wi = round_sh(wv * icr_offset, ddpe_pkg::FRAC_BITS);
    vx = round_sh(longint'(c.v) * co + wi * si, ddpe_pkg::FRAC_BITS);
    vy = round_sh(longint'(c.v) * si - wi * co, ddpe_pkg::FRAC_BITS);
    r.nx = 32'(sat_field(longint'(c.px) + round_sh(scale_by_step(vx), ddpe_pkg::FRAC_BITS),
                         ov));
    r.ny = 32'(sat_field(longint'(c.py) + round_sh(scale_by_step(vy), ddpe_pkg::FRAC_BITS),
                         ov));
    r.nh = 32'(sat_field(longint'(c.ph) + round_sh(wv * step_len, ddpe_pkg::FRAC_BITS), ov));
    r.ov = ov;
    return r;
  endfunction

  task automatic write_reg(logic [ddpe_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
    if (idx == ddpe_pkg::REG_STEP_TIME) step_len = val[23:0];
    else if (idx == ddpe_pkg::REG_ROT_OFFSET) icr_offset = longint'(signed'(val));
  endtask

  task automatic send_pose(pose_cmd_t c, logic known, pose_res_t res, logic gaps);
    int g;
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      g = $urandom_range(1, 6);
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= c;
    pending_poses.push_back(known ? res : predict_pose(c));
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_pipe();
    s_tvalid <= 0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 8) << 16;
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic pose_cmd_t rand_pose();
    pose_cmd_t c;
    c.px = rand_word();
    c.py = rand_word();
    c.ph = rand_word();
    c.v = rand_word();
    c.w = rand_word();
    return c;
  endfunction

  // output side: stall and compare
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      hold_cycles <= 0;
      idle_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %h", m_tdata);
        end else begin
          pose_res_t e;
          e = pending_poses.pop_front();
          if (m_tdata != {e.nh, e.ny, e.nx} || m_tuser[0] !== e.ov) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h ov %b got %h ov %b",
                       e.nx, e.ny, e.nh, e.ov, m_tdata, m_tuser);
          end
        end
      end
      if (stall_mode == 2 && hold_cycles < 200) begin
        m_tready <= 0;
        hold_cycles <= hold_cycles + 1;
      end else if (stall_mode == 0) begin
        if (idle_left > 0) begin
          m_tready <= 0;
          idle_left <= idle_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
          m_tready <= 0;
          idle_left <= $urandom_range(0, 5);
        end else begin
          m_tready <= 1;
        end
      end else begin
        m_tready <= 1;
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    pose_res_t none;
    int n;
    mismatches = 0;
    stall_mode = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    step_len = 6554;
    icr_offset = 0;
    none = '{0, 0, 0, 0};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // after reset: directed rows, starting with a zero pose that stays put
    rw.known = 1;
    rw.cmd = '0;
    rw.res = '{0, 0, 0, 0};
    rows.push_back(rw);
    rw.cmd = '{w: 32'sh7FFFFFFF, v: 0, ph: 32'sh7FFFFFFF, py: 0, px: 0};
    rw.res = '{0, 0, 32'h7FFFFFFF, 1};
    rows.push_back(rw);
    rw.cmd = '{w: 32'sh80000000, v: 0, ph: 32'sh80000000, py: 0, px: 0};
    rw.res = '{0, 0, 32'h80000000, 1};
    rows.push_back(rw);
    rw.known = 0;
    rw.cmd = '{w: 32'sh00010000, v: 32'sh00010000, ph: 0, py: 5, px: -5};
    rows.push_back(rw);
    rw.cmd = '{w: -65536, v: 32'sh7FFFFFFF, ph: 32'sh0001921F, py: 32'sh7FFFFFFF,
               px: 32'sh7FFFFFFF};
    rows.push_back(rw);
    rw.cmd = '{w: 12345, v: 32'sh80000000, ph: 32'sh0003243F, py: 32'sh80000000,
               px: 32'sh80000000};
    rows.push_back(rw);
    rw.cmd = '{w: 1, v: 32'sh00020000, ph: -32'sh0001921F, py: 0, px: 0};
    rows.push_back(rw);
    rw.cmd = '{w: 0, v: 32'sh00030000, ph: 32'sh40000000, py: 0, px: 0};
    rows.push_back(rw);
    foreach (rows[i]) send_pose(rows[i].cmd, rows[i].known, rows[i].res, 0);
    drain_pipe();

    // zero step: pose unchanged
    write_reg(ddpe_pkg::REG_STEP_TIME, 32'hFF000000);
    write_reg(ddpe_pkg::REG_ROT_OFFSET, 32'h7FFFFFFF);
    write_reg(8'hFE, 32'h12345678);
    for (int i = 0; i < 4; i++) begin
      rw.cmd = rand_pose();
      rw.res = '{rw.cmd.px, rw.cmd.py, rw.cmd.ph, 0};
      send_pose(rw.cmd, 1, rw.res, 0);
    end
    drain_pipe();

    // full-scale step and most negative offset
    write_reg(ddpe_pkg::REG_STEP_TIME, 32'h00FFFFFF);
    write_reg(ddpe_pkg::REG_ROT_OFFSET, 32'h80000000);
    for (int i = 0; i < 6; i++) send_pose(rand_pose(), 0, none, 0);
    drain_pipe();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(ddpe_pkg::REG_STEP_TIME,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 17));
      write_reg(ddpe_pkg::REG_ROT_OFFSET,
                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 18) - (1 << 17));
      stall_mode = (ph == 1) ? 2 : (ph == 3) ? 1 : 0;
      n = 0;
      while (n < 200) begin
        send_pose(rand_pose(), 0, none, ph != 3);
        n++;
      end
      drain_pipe();
    end

    if (mismatches == 0) begin
      $display("diff_drive_pose_euler_step test passed");
    end else begin
      $display("diff_drive_pose_euler_step test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== diff_drive_pose_euler_step.f =====
sv/ddpe_pkg.sv
sv/ddpe_reduce.sv
sv/ddpe_cordic.sv
sv/ddpe_update.sv
sv/diff_drive_pose_euler_step.sv
test/tb_top.sv
